FILE: hw/rtl/pmv_pkg.sv
package pmv_pkg;

    localparam int POS_W   = 24;
    localparam int ERR_W   = POS_W + 1;
    localparam int CNT_W   = 16;
    localparam int PWR_W   = 7;
    localparam int DLY_W   = 17;
    localparam int OUT_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 3;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 16;

    localparam logic [PWR_W-1:0] SETTLE_POWER = 7'd30;
    localparam int               RAISE_SIGN   = 1;

    localparam logic [1:0] KIND_DRIVE = 2'd0;
    localparam logic [1:0] KIND_HOLD  = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    localparam logic [2:0] ST_MOVING    = 3'd0;
    localparam logic [2:0] ST_SETTLING  = 3'd1;
    localparam logic [2:0] ST_DONE      = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_STALLED   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;
    localparam logic [2:0] ST_IDLE      = 3'd6;

    localparam logic [CFG_A_W-1:0] REG_TOLERANCE = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_SLOW_ZONE = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_MIN_POWER = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_STALL_DIST = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_STALL_TICKS = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_TIMEOUT = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_SETTLE = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_STEADY = 3'd7;

    localparam logic [CNT_W-1:0] RST_TOLERANCE   = 16'd5;
    localparam logic [CNT_W-1:0] RST_SLOW_ZONE   = 16'd60;
    localparam logic [PWR_W-1:0] RST_MIN_POWER   = 7'd20;
    localparam logic [CNT_W-1:0] RST_STALL_DIST  = 16'd3;
    localparam logic [CNT_W-1:0] RST_STALL_TICKS = 16'd50;
    localparam logic [CNT_W-1:0] RST_TIMEOUT     = 16'd300;
    localparam logic [CNT_W-1:0] RST_SETTLE      = 16'd50;
    localparam logic [CNT_W-1:0] RST_STEADY      = 16'd10;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MOVE,
        PH_SETTLE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_SCALE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV
    } t_sc_state;

    // request to the serial scaler: floor(top * aerr / zone)
    typedef struct packed {
        logic              start;
        logic [PWR_W-1:0]  top;
        logic [CNT_W-1:0]  aerr;
        logic [CNT_W-1:0]  zone;
    } t_scale_req;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // magnitude to signed drive command, with motor direction applied
    function automatic logic [OUT_W-1:0] signed_power(input logic [PWR_W-1:0] mag,
                                                       input logic neg);
        logic [OUT_W-1:0] v;
        v = {1'b0, mag};
        if (neg)
            v = OUT_W'(-v);
        if (RAISE_SIGN > 0)
            signed_power = v;
        else if (RAISE_SIGN < 0)
            signed_power = OUT_W'(-v);
        else
            signed_power = '0;
    endfunction

endpackage

FILE: hw/rtl/pmv_scale.sv
module pmv_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pmv_pkg::t_scale_req            i_req,
    output logic                           o_done,
    output logic [pmv_pkg::PWR_W-1:0]      o_quot
);
    import pmv_pkg::*;

    localparam int PROD_W    = PWR_W + CNT_W;
    localparam int MUL_STEPS = PWR_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    t_sc_state r_state, n_state;

    logic [STEP_W-1:0] r_cnt;
    logic [PWR_W-1:0]  r_mplier;
    logic [PROD_W-1:0] r_mcand;
    logic [PROD_W-1:0] r_acc;     // product, then dividend/quotient
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_zone;
    logic              r_done;

    logic [CNT_W:0]    rem_sh;
    logic              q_bit;
    logic              last_step;

    assign rem_sh = {r_rem, r_acc[PROD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_zone});

    always_comb begin
        n_state   = r_state;
        last_step = 1'b0;
        unique case (r_state)
            SC_IDLE: begin
                if (i_req.start)
                    n_state = SC_MUL;
            end
            SC_MUL: begin
                if (r_cnt == STEP_W'(MUL_STEPS - 1))
                    n_state = SC_DIV;
            end
            SC_DIV: begin
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    last_step = 1'b1;
                    n_state   = SC_IDLE;
                end
            end
            default: n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= last_step;
            if (r_state != n_state)
                r_cnt <= '0;
            else
                r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SC_IDLE: begin
                r_mplier <= i_req.top;
                r_mcand  <= PROD_W'(i_req.aerr);
                r_zone   <= i_req.zone;
                r_acc    <= '0;
                r_rem    <= '0;
            end
            SC_MUL: begin
                // shift-add, one multiplier bit per cycle
                if (r_mplier[0])
                    r_acc <= r_acc + r_mcand;
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
            end
            SC_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (q_bit)
                    r_rem <= CNT_W'(rem_sh - {1'b0, r_zone});
                else
                    r_rem <= rem_sh[CNT_W-1:0];
                r_acc <= {r_acc[PROD_W-2:0], q_bit};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_acc[PWR_W-1:0];

endmodule

FILE: hw/rtl/position_move_with_settle_and_stall.sv
// Position move controller. A start transaction (tuser 0) loads the goal, top speed and
// action delay; each tick transaction (tuser 1) carries one position sample and a cancel
// flag and yields exactly one result: a drive command, brake/hold or stop, an action
// strobe and a status code. Inside the slow zone the drive magnitude is
// floor(top * |err| / slow_zone), at least the minimum power, worked out by a bit-serial
// shift-add multiplier followed by a restoring divider. Each result passes the calc,
// decide and emit states; a tick that needs the proportional speed also waits in the
// scale state for the serial scaler. One transaction is in work at a time; the input is
// ready again as soon as the result is in the output register, even if the consumer has
// not yet taken it. Configuration writes are applied on the cycle they are presented.
module position_move_with_settle_and_stall (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: target[23:0], speed_limit[30:24], action_delay[47:31], position[71:48],
    //        cancel[72], zero fill
    input  logic [pmv_pkg::S_DATA_W-1:0]      i_s_tdata,
    input  logic                              i_s_tuser,  // mode
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: drive_power[7:0], action_fire[8], status[11:9], zero fill
    output logic [pmv_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic [1:0]                        o_m_tuser,  // drive_kind
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic                              i_cfg_we,
    input  logic [pmv_pkg::CFG_A_W-1:0]       i_cfg_addr,
    input  logic [pmv_pkg::CFG_W-1:0]         i_cfg_data
);
    import pmv_pkg::*;

    // configuration
    logic [CNT_W-1:0] r_tol, r_zone, r_sdist, r_sticks, r_tmo, r_stl, r_sty;
    logic [PWR_W-1:0] r_minp;

    // move state
    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_goal, n_goal;
    logic [PWR_W-1:0] r_top, n_top;
    logic [DLY_W-1:0] r_delay, n_delay;
    logic             r_pending, n_pending;
    logic [CNT_W-1:0] r_ticks, n_ticks;
    logic [POS_W-1:0] r_ppos, n_ppos;
    logic [CNT_W-1:0] r_ptick, n_ptick;
    logic [CNT_W-1:0] r_settle, n_settle;
    logic [CNT_W-1:0] r_steady, n_steady;

    // captured transaction
    logic             r_mode, r_cancel;
    logic [POS_W-1:0] r_tgt, r_pos;
    logic [PWR_W-1:0] r_spd;
    logic [DLY_W-1:0] r_dly;

    // error terms
    logic [ERR_W-1:0] r_aerr, r_pdiff;
    logic             r_eneg;

    // pending result
    logic [OUT_W-1:0] r_res_power, n_res_power;
    logic [1:0]       r_res_kind, n_res_kind;
    logic             r_res_fire, n_res_fire;
    logic [2:0]       r_res_status, n_res_status;
    logic             r_neg, n_neg;

    // output register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [1:0]          r_out_user;

    logic             s_acc;
    logic [ERR_W-1:0] err, pd;
    logic [POS_W-1:0] pref;
    logic [CNT_W-1:0] k, pteff;
    logic             fire, pend, in_tol, out_load;
    logic [PWR_W-1:0] top_mag, q_mag;
    t_scale_req       scale_req;
    logic             scale_go, scale_done;
    logic [PWR_W-1:0] scale_quot;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    assign scale_req.start = scale_go;
    assign scale_req.top   = r_top;
    assign scale_req.aerr  = r_aerr[CNT_W-1:0];
    assign scale_req.zone  = r_zone;

    pmv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scale_req),
        .o_done  (scale_done),
        .o_quot  (scale_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= RST_TOLERANCE;
            r_zone   <= RST_SLOW_ZONE;
            r_minp   <= RST_MIN_POWER;
            r_sdist  <= RST_STALL_DIST;
            r_sticks <= RST_STALL_TICKS;
            r_tmo    <= RST_TIMEOUT;
            r_stl    <= RST_SETTLE;
            r_sty    <= RST_STEADY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TOLERANCE:   r_tol    <= i_cfg_data;
                REG_SLOW_ZONE:   r_zone   <= i_cfg_data;
                REG_MIN_POWER:   r_minp   <= i_cfg_data[PWR_W-1:0];
                REG_STALL_DIST:  r_sdist  <= i_cfg_data;
                REG_STALL_TICKS: r_sticks <= i_cfg_data;
                REG_TIMEOUT:     r_tmo    <= i_cfg_data;
                REG_SETTLE:      r_stl    <= i_cfg_data;
                REG_STEADY:      r_sty    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture and error terms
    assign err  = {r_goal[POS_W-1], r_goal} - {r_pos[POS_W-1], r_pos};
    assign pref = (r_ticks == '0) ? r_pos : r_ppos;
    assign pd   = {r_pos[POS_W-1], r_pos} - {pref[POS_W-1], pref};

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode   <= i_s_tuser;
            r_tgt    <= i_s_tdata[23:0];
            r_spd    <= i_s_tdata[30:24];
            r_dly    <= i_s_tdata[47:31];
            r_pos    <= i_s_tdata[71:48];
            r_cancel <= i_s_tdata[72];
        end
        if (r_state == S_CALC) begin
            r_aerr  <= err[ERR_W-1] ? ERR_W'(-err) : err;
            r_eneg  <= err[ERR_W-1];
            r_pdiff <= pd[ERR_W-1] ? ERR_W'(-pd) : pd;
        end
    end

    // decision logic
    assign k       = r_ticks;
    assign pteff   = (k == '0) ? '0 : r_ptick;
    assign fire    = r_pending && (k >= r_delay[CNT_W-1:0]);
    assign pend    = r_pending && !fire;
    assign in_tol  = (r_aerr <= ERR_W'(r_tol));
    assign top_mag = (r_top < r_minp) ? r_minp : r_top;
    assign q_mag   = (scale_quot < r_minp) ? r_minp : scale_quot;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_goal       = r_goal;
        n_top        = r_top;
        n_delay      = r_delay;
        n_pending    = r_pending;
        n_ticks      = r_ticks;
        n_ppos       = r_ppos;
        n_ptick      = r_ptick;
        n_settle     = r_settle;
        n_steady     = r_steady;
        n_res_power  = r_res_power;
        n_res_kind   = r_res_kind;
        n_res_fire   = r_res_fire;
        n_res_status = r_res_status;
        n_neg        = r_neg;
        scale_go     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc)
                    n_state = S_CALC;
            end
            S_CALC: n_state = S_DECIDE;
            S_DECIDE: begin
                n_state      = S_EMIT;
                n_res_power  = '0;
                n_res_fire   = 1'b0;
                n_res_kind   = KIND_STOP;
                n_res_status = ST_IDLE;
                if (!r_mode) begin
                    n_goal       = r_tgt;
                    n_top        = r_spd;
                    n_delay      = r_dly;
                    n_pending    = !r_dly[DLY_W-1];
                    n_ticks      = '0;
                    n_ppos       = '0;
                    n_ptick      = '0;
                    n_settle     = '0;
                    n_steady     = '0;
                    n_phase      = PH_MOVE;
                    n_res_status = ST_MOVING;
                end else if (r_phase == PH_MOVE) begin
                    if (k >= r_tmo) begin
                        n_phase      = PH_IDLE;
                        n_res_status = ST_TIMEOUT;
                    end else if (r_cancel) begin
                        n_phase      = PH_IDLE;
                        n_res_status = ST_CANCELLED;
                    end else begin
                        n_pending  = pend;
                        n_res_fire = fire;
                        n_ticks    = sat_inc(k);
                        if (k == '0) begin
                            n_ppos  = r_pos;
                            n_ptick = '0;
                        end
                        if (in_tol) begin
                            n_res_kind = KIND_HOLD;
                            if (r_stl == '0 || r_sty == '0) begin
                                n_res_fire   = fire || pend;
                                n_pending    = 1'b0;
                                n_phase      = PH_IDLE;
                                n_res_status = ST_DONE;
                            end else begin
                                n_phase      = PH_SETTLE;
                                n_settle     = CNT_W'(1);
                                n_steady     = CNT_W'(1);
                                n_res_status = ST_SETTLING;
                            end
                        end else if (r_pdiff < ERR_W'(r_sdist) &&
                                     r_aerr > ERR_W'(r_zone) &&
                                     (k - pteff) > r_sticks) begin
                            n_phase      = PH_IDLE;
                            n_res_status = ST_STALLED;
                        end else begin
                            if (r_pdiff >= ERR_W'(r_sdist)) begin
                                n_ppos  = r_pos;
                                n_ptick = k;
                            end
                            n_res_kind   = KIND_DRIVE;
                            n_res_status = ST_MOVING;
                            n_neg        = r_eneg;
                            if (r_aerr >= ERR_W'(r_zone)) begin
                                n_res_power = signed_power(top_mag, r_eneg);
                            end else begin
                                scale_go = 1'b1;
                                n_state  = S_SCALE;
                            end
                        end
                    end
                end else if (r_phase == PH_SETTLE) begin
                    if (r_settle >= r_stl) begin
                        n_res_fire   = r_pending;
                        n_pending    = 1'b0;
                        n_phase      = PH_IDLE;
                        n_res_kind   = KIND_HOLD;
                        n_res_status = ST_DONE;
                    end else if (r_cancel) begin
                        n_phase      = PH_IDLE;
                        n_res_status = ST_CANCELLED;
                    end else if (!in_tol) begin
                        // push back toward the goal at the settle power
                        n_steady     = CNT_W'(1);
                        n_settle     = sat_inc(r_settle);
                        n_res_kind   = KIND_DRIVE;
                        n_res_status = ST_SETTLING;
                        n_res_power  = signed_power(SETTLE_POWER, r_eneg);
                    end else if (r_steady >= r_sty) begin
                        n_res_fire   = r_pending;
                        n_pending    = 1'b0;
                        n_phase      = PH_IDLE;
                        n_res_kind   = KIND_HOLD;
                        n_res_status = ST_DONE;
                    end else begin
                        n_steady     = sat_inc(r_steady);
                        n_settle     = sat_inc(r_settle);
                        n_res_kind   = KIND_HOLD;
                        n_res_status = ST_SETTLING;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            S_SCALE: begin
                if (scale_done) begin
                    n_res_power = signed_power(q_mag, r_neg);
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_goal    <= '0;
            r_top     <= '0;
            r_delay   <= '1;
            r_pending <= 1'b0;
            r_ticks   <= '0;
            r_ppos    <= '0;
            r_ptick   <= '0;
            r_settle  <= '0;
            r_steady  <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_goal    <= n_goal;
            r_top     <= n_top;
            r_delay   <= n_delay;
            r_pending <= n_pending;
            r_ticks   <= n_ticks;
            r_ppos    <= n_ppos;
            r_ptick   <= n_ptick;
            r_settle  <= n_settle;
            r_steady  <= n_steady;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_power  <= n_res_power;
        r_res_kind   <= n_res_kind;
        r_res_fire   <= n_res_fire;
        r_res_status <= n_res_status;
        r_neg        <= n_neg;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {4'd0, r_res_status, r_res_fire, r_res_power};
            r_out_user <= r_res_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pmv_pkg::*;

    localparam int PHASE_ITEMS  = 225;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        bit is_tick;
        int target;
        int speed;
        int delay;
        int pos;
        bit cancel;
    } t_motion_req;

    typedef struct {
        logic [OUT_W-1:0] power;
        logic [1:0]       kind;
        logic             fire;
        logic [2:0]       status;
    } t_motor_cmd;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    // register copies
    int cfg_tol = RST_TOLERANCE, cfg_slow = RST_SLOW_ZONE, cfg_minp = RST_MIN_POWER;
    int cfg_sdist = RST_STALL_DIST, cfg_sticks = RST_STALL_TICKS, cfg_tout = RST_TIMEOUT;
    int cfg_settle = RST_SETTLE, cfg_steady = RST_STEADY;

    // move state
    t_phase mv_phase = PH_IDLE;
    int     mv_goal = 0, mv_top = 0, mv_delay = -1, mv_ticks = 0;
    bit     mv_fire_pending = 1'b0;
    int     ref_pos = 0, ref_tick = 0, settle_cnt = 0, steady_cnt = 0;

    t_motion_req pending_moves[$];
    t_motor_cmd  due_cmds[$];
    t_motion_req in_flight;
    t_motor_cmd  next_cmd;

    int tx_idle_pct = 26, rx_idle_pct = 52;
    int hold_requests = 0, holds_seen = 0, hold_left = 0;
    int errors = 0, moves_in = 0, cmds_checked = 0;
    int n_done = 0, n_stalled = 0, n_timeout = 0, n_cancelled = 0, n_fired = 0;

    position_move_with_settle_and_stall dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int bump(input int c);
        return (c < 65535) ? c + 1 : c;
    endfunction

    function automatic t_motor_cmd make_cmd(input int pw, input logic [1:0] kind,
                                            input logic fire, input logic [2:0] st);
        t_motor_cmd c;
        c.power  = OUT_W'(pw);
        c.kind   = kind;
        c.fire   = fire;
        c.status = st;
        return c;
    endfunction

    task automatic step_motor_model(input t_motion_req q, output t_motor_cmd c);
        int   k, err, aerr, pw;
        logic fire;
        fire = 1'b0;
        if (!q.is_tick) begin
            mv_goal = q.target;
            mv_top = q.speed;
            mv_delay = q.delay;
            mv_fire_pending = (q.delay >= 0);
            mv_ticks = 0;
            ref_pos = 0;
            ref_tick = 0;
            settle_cnt = 0;
            steady_cnt = 0;
            mv_phase = PH_MOVE;
            c = make_cmd(0, KIND_STOP, 1'b0, ST_MOVING);
            return;
        end
        if (mv_phase == PH_MOVE) begin
            k = mv_ticks;
            if (k >= cfg_tout) begin
                mv_phase = PH_IDLE;
                c = make_cmd(0, KIND_STOP, 1'b0, ST_TIMEOUT);
                return;
            end
            if (q.cancel) begin
                mv_phase = PH_IDLE;
                c = make_cmd(0, KIND_STOP, 1'b0, ST_CANCELLED);
                return;
            end
            if (mv_fire_pending && k >= mv_delay) begin
                mv_fire_pending = 1'b0;
                fire = 1'b1;
            end
            if (k == 0) begin
                ref_pos = q.pos;
                ref_tick = 0;
            end
            mv_ticks = bump(k);
            err = mv_goal - q.pos;
            aerr = magnitude(err);
            if (aerr <= cfg_tol) begin
                if (cfg_settle == 0 || cfg_steady == 0) begin
                    if (mv_fire_pending) begin
                        mv_fire_pending = 1'b0;
                        fire = 1'b1;
                    end
                    mv_phase = PH_IDLE;
                    c = make_cmd(0, KIND_HOLD, fire, ST_DONE);
                    return;
                end
                mv_phase = PH_SETTLE;
                settle_cnt = 1;
                steady_cnt = 1;
                c = make_cmd(0, KIND_HOLD, fire, ST_SETTLING);
                return;
            end
            if (magnitude(q.pos - ref_pos) >= cfg_sdist) begin
                ref_pos = q.pos;
                ref_tick = k;
            end else if (aerr > cfg_slow && (k - ref_tick) > cfg_sticks) begin
                mv_phase = PH_IDLE;
                c = make_cmd(0, KIND_STOP, fire, ST_STALLED);
                return;
            end
            // slow zone of zero never divides: every error is at or above it
            if (aerr >= cfg_slow) begin
                pw = mv_top;
            end else begin
                pw = (mv_top * aerr) / cfg_slow;
            end
            if (pw < cfg_minp) pw = cfg_minp;
            if (err < 0) pw = -pw;
            c = make_cmd(pw * RAISE_SIGN, KIND_DRIVE, fire, ST_MOVING);
        end else if (mv_phase == PH_SETTLE) begin
            if (settle_cnt >= cfg_settle) begin
                if (mv_fire_pending) begin
                    mv_fire_pending = 1'b0;
                    fire = 1'b1;
                end
                mv_phase = PH_IDLE;
                c = make_cmd(0, KIND_HOLD, fire, ST_DONE);
                return;
            end
            if (q.cancel) begin
                mv_phase = PH_IDLE;
                c = make_cmd(0, KIND_STOP, 1'b0, ST_CANCELLED);
                return;
            end
            err = mv_goal - q.pos;
            if (magnitude(err) > cfg_tol) begin
                steady_cnt = 1;
                settle_cnt = bump(settle_cnt);
                pw = (err > 0) ? int'(SETTLE_POWER) : -int'(SETTLE_POWER);
                c = make_cmd(pw * RAISE_SIGN, KIND_DRIVE, 1'b0, ST_SETTLING);
                return;
            end
            if (steady_cnt >= cfg_steady) begin
                if (mv_fire_pending) begin
                    mv_fire_pending = 1'b0;
                    fire = 1'b1;
                end
                mv_phase = PH_IDLE;
                c = make_cmd(0, KIND_HOLD, fire, ST_DONE);
                return;
            end
            steady_cnt = bump(steady_cnt);
            settle_cnt = bump(settle_cnt);
            c = make_cmd(0, KIND_HOLD, 1'b0, ST_SETTLING);
        end else begin
            mv_phase = PH_IDLE;
            c = make_cmd(0, KIND_STOP, 1'b0, ST_IDLE);
        end
    endtask

    // fields are trimmed to port widths so the model sees what the block sees
    task automatic queue_req(input bit is_tick, input int tgt, input int spd, input int dly,
                             input int pos, input bit cxl);
        t_motion_req t;
        t.is_tick = is_tick;
        t.target  = int'($signed(24'(tgt)));
        t.speed   = spd & 'h7F;
        t.delay   = int'($signed(17'(dly)));
        t.pos     = int'($signed(24'(pos)));
        t.cancel  = cxl;
        pending_moves.push_back(t);
    endtask

    task automatic queue_move();
        int tgt, dly, pos, style, n, step, jit, pick;
        if ($urandom_range(3) == 0) tgt = $urandom;
        else tgt = int'($urandom_range(4000)) - 2000;
        pick = $urandom_range(99);
        if (pick < 50) dly = $urandom_range(30);
        else if (pick < 65) dly = -1;
        else if (pick < 75) dly = -int'($urandom_range(1, 65536));
        else if (pick < 85) dly = $urandom_range(65535);
        else dly = $urandom;
        queue_req(1'b0, tgt, $urandom_range(127), dly, $urandom, $urandom_range(1));
        if ($urandom_range(9) == 0) pos = $urandom;
        else pos = tgt + int'($urandom_range(1200)) - 600;
        style = $urandom_range(3);
        n = $urandom_range(2, 40);
        jit = cfg_tol + 3;
        repeat (n) begin
            queue_req(1'b1, $urandom, $urandom, $urandom, pos, $urandom_range(99) < 3);
            case (style)
                0: begin
                    step = (tgt - pos) / int'($urandom_range(2, 5));
                    if (step == 0) step = tgt - pos;
                    pos = pos + step + int'($urandom_range(4)) - 2;
                end
                1: pos = pos + int'($urandom_range(2)) - 1;    // barely moving
                2: pos = pos + int'($urandom_range(200)) - 100;
                default: pos = tgt + int'($urandom_range(2 * jit)) - jit;
            endcase
        end
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 4))
            queue_req($urandom_range(1), $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(1));
    endtask

    task automatic program_register(input logic [CFG_A_W-1:0] addr, input int val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= CFG_W'(val);
        case (addr)
            REG_TOLERANCE:   cfg_tol = val & 'hFFFF;
            REG_SLOW_ZONE:   cfg_slow = val & 'hFFFF;
            REG_MIN_POWER:   cfg_minp = val & 'h7F;
            REG_STALL_DIST:  cfg_sdist = val & 'hFFFF;
            REG_STALL_TICKS: cfg_sticks = val & 'hFFFF;
            REG_TIMEOUT:     cfg_tout = val & 'hFFFF;
            REG_SETTLE:      cfg_settle = val & 'hFFFF;
            default:         cfg_steady = val & 'hFFFF;
        endcase
    endtask

    task automatic apply_settings(input int tol, input int slow, input int minp,
                                  input int sdist, input int sticks, input int tout,
                                  input int settle, input int steady);
        program_register(REG_TOLERANCE, tol);
        program_register(REG_SLOW_ZONE, slow);
        program_register(REG_MIN_POWER, minp);
        program_register(REG_STALL_DIST, sdist);
        program_register(REG_STALL_TICKS, sticks);
        program_register(REG_TIMEOUT, tout);
        program_register(REG_SETTLE, settle);
        program_register(REG_STEADY, steady);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_moves.size() != 0 || s_tvalid || due_cmds.size() != 0)
            @(negedge clk);
    endtask

    task automatic flag_mismatch(input string what, input int expv, input int actv);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
        errors++;
    endtask

    // sender: predicts on every accepted transaction
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_motor_model(in_flight, next_cmd);
                due_cmds.push_back(next_cmd);
                moves_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_moves.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    in_flight = pending_moves.pop_front();
                    s_tdata  <= {7'b0, in_flight.cancel, 24'(in_flight.pos),
                                 17'(in_flight.delay), 7'(in_flight.speed),
                                 24'(in_flight.target)};
                    s_tuser  <= in_flight.is_tick;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure plus an occasional long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (holds_seen != hold_requests) begin
            holds_seen <= hold_requests;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_motor_cmd e;
        if (rst_n && m_tvalid && m_tready) begin
            case (m_tdata[11:9])
                ST_DONE:      n_done++;
                ST_STALLED:   n_stalled++;
                ST_TIMEOUT:   n_timeout++;
                ST_CANCELLED: n_cancelled++;
                default: ;
            endcase
            if (m_tdata[8]) n_fired++;
            if (due_cmds.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, m_tdata[11:9]);
                errors++;
            end else begin
                e = due_cmds.pop_front();
                cmds_checked++;
                if (m_tdata[7:0] !== e.power)
                    flag_mismatch("drive_power", $signed(e.power), $signed(m_tdata[7:0]));
                if (m_tuser !== e.kind)
                    flag_mismatch("drive_kind", e.kind, m_tuser);
                if (m_tdata[8] !== e.fire)
                    flag_mismatch("action_fire", e.fire, m_tdata[8]);
                if (m_tdata[11:9] !== e.status)
                    flag_mismatch("status", e.status, m_tdata[11:9]);
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset register values
        queue_req(1'b1, 0, 0, 0, 123, 1'b1);
        queue_req(1'b0, 8388607, 127, -1, 0, 1'b0);
        queue_req(1'b1, 0, 0, 0, -8388608, 1'b0);
        queue_req(1'b1, 0, 0, 0, 8388607, 1'b0);
        queue_req(1'b1, 0, 0, 0, 8388507, 1'b0);
        queue_req(1'b1, 0, 0, 0, 8388607, 1'b1);
        queue_req(1'b0, -8388608, 0, 65535, 0, 1'b0);
        queue_req(1'b1, 0, 0, 0, 8388607, 1'b0);
        queue_req(1'b0, 0, 100, 0, 0, 1'b0);           // restart mid-move
        queue_req(1'b1, 0, 0, 0, 30, 1'b0);
        queue_req(1'b1, 0, 0, 0, -10, 1'b0);
        queue_req(1'b1, 0, 0, 0, 3, 1'b0);
        queue_req(1'b1, 0, 0, 0, -40, 1'b0);
        queue_req(1'b1, 0, 0, 0, 40, 1'b0);
        queue_req(1'b1, 0, 0, 0, 2, 1'b0);
        queue_req(1'b0, 1000, 127, -65536, 0, 1'b0);
        queue_req(1'b1, 0, 0, 0, 0, 1'b0);
        queue_req(1'b1, 0, 0, 0, 0, 1'b1);
        queue_req(1'b0, -500, 64, 2, 0, 1'b0);
        queue_req(1'b1, 0, 0, 0, 0, 1'b0);
        queue_req(1'b1, 0, 0, 0, -200, 1'b0);
        queue_req(1'b1, 0, 0, 0, -498, 1'b0);
        queue_req(1'b1, 0, 0, 0, 0, 1'b0);
        wait_drained();

        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: apply_settings(5, 60, 20, 3, 6, 30, 12, 4);
                2: apply_settings(0, 0, 0, 0, 1, 1, 0, 0);
                3: apply_settings(65535, 65535, 127, 65535, 65535, 65535, 65535, 65535);
                default: apply_settings($urandom_range(40),
                                        (ph == 5) ? 0 : $urandom_range(300),
                                        $urandom_range(127), $urandom_range(12),
                                        $urandom_range(1, 12), $urandom_range(4, 60),
                                        $urandom_range(20), $urandom_range(8));
            endcase
            if (ph <= 2) begin
                tx_idle_pct = 26;
                rx_idle_pct = 52;
            end else if (ph <= 4) begin
                tx_idle_pct = 52;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            while (pending_moves.size() < PHASE_ITEMS) begin
                if ($urandom_range(99) < 82) queue_move();
                else queue_noise();
            end
            if (ph == 5) begin
                @(posedge clk);
                hold_requests <= hold_requests + 1;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d transactions in, %0d results checked over 7 register settings",
                 moves_in, cmds_checked);
        $display("outcomes: done %0d, stalled %0d, timeout %0d, cancelled %0d, fires %0d",
                 n_done, n_stalled, n_timeout, n_cancelled, n_fired);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d results still awaited", due_cmds.size());
        $display("tb_top failed");
        $finish;
    end

endmodule
